// ===== src/bcm_pkg.sv =====
// Shared types and constants of the bristle color mixer.
`timescale 1ns / 1ps

package bcm_pkg;

    // Fixed field widths
    localparam int COLOR_W    = 8;
    localparam int BRISTLE_W  = 8;
    localparam int STEP_W     = 16;
    localparam int ALPHA_W    = 8;
    localparam int STRENGTH_W = 16;
    localparam int ARGB_W     = 32;

    // Blend weight is a fraction over 2**WEIGHT_SHIFT
    localparam int WEIGHT_SHIFT = 16;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_STRENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALPHA       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_START_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_ARGB = 2'd3;

    // Configuration reset values
    localparam logic [STRENGTH_W-1:0] MIX_STRENGTH_RST   = 16'd786;
    localparam logic [ALPHA_W-1:0]    MIN_ALPHA_RST      = 8'd20;
    localparam logic [STEP_W-1:0]     MIX_START_STEP_RST = 16'd5;
    localparam logic [ARGB_W-1:0]     BACKGROUND_RST     = 32'd0;

    // Request kinds on the input stream
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Operation the back end carries out
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_KEEP,
        OP_MIX
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [BRISTLE_W-1:0] bristle;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/bcm_front.sv =====
// Front end: accepts items, drops out-of-range bristles and decides load, keep or mix.
`timescale 1ns / 1ps

module bcm_front #(
    parameter int BRISTLE_COUNT = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic [bcm_pkg::BRISTLE_W-1:0]      i_bristle_index,
    input  logic [bcm_pkg::STEP_W-1:0]         i_step_index,
    input  logic [bcm_pkg::ALPHA_W-1:0]        i_step_alpha,
    input  logic [bcm_pkg::ALPHA_W-1:0]        i_sample_alpha,
    input  logic [bcm_pkg::COLOR_W-1:0]        i_sample_red,
    input  logic [bcm_pkg::COLOR_W-1:0]        i_sample_green,
    input  logic [bcm_pkg::COLOR_W-1:0]        i_sample_blue,
    input  logic [bcm_pkg::ALPHA_W-1:0]        i_min_alpha,
    input  logic [bcm_pkg::STEP_W-1:0]         i_mix_start_step,
    input  logic [bcm_pkg::ARGB_W-1:0]         i_background_argb,
    input  bcm_pkg::t_q_status                 i_q_status,
    output logic                               o_push,
    output bcm_pkg::t_cmd                      o_cmd
);
    import bcm_pkg::*;

    logic                r_valid;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic                in_range;
    logic                mix;
    logic [ARGB_W-1:0]   argb;

    // Classify the incoming item
    always_comb begin
        in_range = {24'd0, i_bristle_index} < 32'(BRISTLE_COUNT);
        argb     = {i_sample_alpha, i_sample_red, i_sample_green, i_sample_blue};
        // a start step of zero behaves as one, so step zero never mixes
        mix      = (i_step_index >= i_mix_start_step) && (i_step_index != '0)
                   && (i_step_alpha >= i_min_alpha) && (i_sample_alpha != '0)
                   && (argb != i_background_argb);
        n_cmd.bristle = i_bristle_index;
        n_cmd.red     = i_sample_red;
        n_cmd.green   = i_sample_green;
        n_cmd.blue    = i_sample_blue;
        if (i_req_type == REQ_LOAD) begin
            n_cmd.op = OP_LOAD;
        end else if (mix) begin
            n_cmd.op = OP_MIX;
        end else begin
            n_cmd.op = OP_KEEP;
        end
    end

    assign o_ready = !r_valid || !i_q_status.full;
    assign o_push  = r_valid && !i_q_status.full;
    assign o_cmd   = r_cmd;

    // Hold the classified item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && in_range;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/bcm_queue.sv =====
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module bcm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bcm_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output bcm_pkg::t_cmd      o_head,
    output bcm_pkg::t_q_status o_status
);
    import bcm_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/bcm_back.sv =====
// Back end: per-bristle color memory with read-modify-write, forwarding and output register.
`timescale 1ns / 1ps

module bcm_back #(
    parameter int BRISTLE_COUNT = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bcm_pkg::t_cmd                 i_head,
    input  bcm_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    input  logic [bcm_pkg::STRENGTH_W-1:0] i_mix_strength,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bcm_pkg::BRISTLE_W-1:0] o_bristle,
    output logic [bcm_pkg::COLOR_W-1:0]   o_red,
    output logic [bcm_pkg::COLOR_W-1:0]   o_green,
    output logic [bcm_pkg::COLOR_W-1:0]   o_blue
);
    import bcm_pkg::*;

    localparam int AW = (BRISTLE_COUNT > 1) ? $clog2(BRISTLE_COUNT) : 1;
    localparam int RW = COLOR_W + FRACTION_BITS;
    localparam int WW = 3 * RW;

    // new = old + floor(s * (painted - old) / 2**WEIGHT_SHIFT), kept modulo 2**RW
    function automatic logic [RW-1:0] f_blend(input logic [RW-1:0] old,
                                              input logic [COLOR_W-1:0] color,
                                              input logic [STRENGTH_W-1:0] s);
        logic signed [RW:0]    diff;
        logic signed [RW+17:0] prod;
        diff = $signed({1'b0, color, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, old});
        prod = $signed({1'b0, s}) * diff;
        return old + prod[RW+WEIGHT_SHIFT-1:WEIGHT_SHIFT];
    endfunction

    logic [WW-1:0] r_ram [BRISTLE_COUNT];
    logic          r_s1_valid;
    t_cmd          r_s1_cmd;
    logic [WW-1:0] r_rd_data;
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [WW-1:0] r_fwd_data;
    logic          r_out_valid;
    logic [BRISTLE_W-1:0] r_out_bristle;
    logic [COLOR_W-1:0]   r_out_red;
    logic [COLOR_W-1:0]   r_out_green;
    logic [COLOR_W-1:0]   r_out_blue;

    logic [AW-1:0] s1_addr;
    logic [AW-1:0] head_addr;
    logic [WW-1:0] old_word;
    logic [WW-1:0] new_word;
    logic          needs_out;
    logic          s1_adv;
    logic          wr_en;

    assign s1_addr   = AW'(r_s1_cmd.bristle);
    assign head_addr = AW'(i_head.bristle);

    // Pick the latest copy of the bristle and compute its next color
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == s1_addr)) begin
            old_word = r_fwd_data;
        end else begin
            old_word = r_rd_data;
        end
        case (r_s1_cmd.op)
            OP_LOAD: begin
                new_word = {r_s1_cmd.red, {FRACTION_BITS{1'b0}},
                            r_s1_cmd.green, {FRACTION_BITS{1'b0}},
                            r_s1_cmd.blue, {FRACTION_BITS{1'b0}}};
            end
            OP_MIX: begin
                new_word = {f_blend(old_word[WW-1:2*RW], r_s1_cmd.red, i_mix_strength),
                            f_blend(old_word[2*RW-1:RW], r_s1_cmd.green, i_mix_strength),
                            f_blend(old_word[RW-1:0], r_s1_cmd.blue, i_mix_strength)};
            end
            default: begin
                new_word = old_word;
            end
        endcase
    end

    // Stage control: loads never wait for the output register
    assign needs_out = r_s1_cmd.op != OP_LOAD;
    assign s1_adv    = !r_s1_valid || !needs_out || !r_out_valid || i_ready;
    assign o_pop     = !i_q_status.empty && s1_adv;
    assign wr_en     = r_s1_valid && s1_adv
                       && (r_s1_cmd.op == OP_LOAD || r_s1_cmd.op == OP_MIX);

    // Color memory: read on pop, write back from the compute stage
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_ram[head_addr];
        end
        if (wr_en) begin
            r_ram[s1_addr] <= new_word;
        end
    end

    // Compute stage, forwarding register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= o_pop;
            end
            if (wr_en) begin
                r_fwd_valid <= 1'b1;
            end
            if (r_s1_valid && needs_out && s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_s1_cmd <= i_head;
        end
        if (wr_en) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= new_word;
        end
        if (r_s1_valid && needs_out && s1_adv) begin
            r_out_bristle <= r_s1_cmd.bristle;
            r_out_red     <= new_word[WW-1:WW-COLOR_W];
            r_out_green   <= new_word[2*RW-1:2*RW-COLOR_W];
            r_out_blue    <= new_word[RW-1:RW-COLOR_W];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_bristle = r_out_bristle;
    assign o_red     = r_out_red;
    assign o_green   = r_out_green;
    assign o_blue    = r_out_blue;

endmodule

// ===== src/bristle_color_mixer_unit.sv =====
// Top level of the bristle color mixer: configuration registers and stream ports.
// A sample item passes the front register, the queue, the compute stage and the
// output register. Throughput: one item per cycle for any bristle order unless the
// output stalls, set by the back-end blend and write-back loop with write forwarding.
// Reset clears control state and restores the configuration defaults; the color
// memory is not cleared, a bristle must be loaded before it is sampled.
`timescale 1ns / 1ps

module bristle_color_mixer_unit #(
    parameter int BRISTLE_COUNT = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bristle_index[7:0], step_index[23:8], step_alpha[31:24], sample_alpha[39:32],
    // sample_red[47:40], sample_green[55:48], sample_blue[63:56]
    input  logic [63:0]                     s_axis_tdata,
    // req_type[0]
    input  logic [0:0]                      s_axis_tuser,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_bristle[7:0], out_red[15:8], out_green[23:16], out_blue[31:24]
    output logic [31:0]                     m_axis_tdata,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bcm_pkg::*;

    logic [STRENGTH_W-1:0] r_mix_strength;
    logic [ALPHA_W-1:0]    r_min_alpha;
    logic [STEP_W-1:0]     r_mix_start_step;
    logic [ARGB_W-1:0]     r_background_argb;

    logic      push;
    logic      pop;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_strength    <= MIX_STRENGTH_RST;
            r_min_alpha       <= MIN_ALPHA_RST;
            r_mix_start_step  <= MIX_START_STEP_RST;
            r_background_argb <= BACKGROUND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIX_STRENGTH:    r_mix_strength    <= i_cfg_data[STRENGTH_W-1:0];
                CFG_MIN_ALPHA:       r_min_alpha       <= i_cfg_data[ALPHA_W-1:0];
                CFG_MIX_START_STEP:  r_mix_start_step  <= i_cfg_data[STEP_W-1:0];
                CFG_BACKGROUND_ARGB: r_background_argb <= i_cfg_data[ARGB_W-1:0];
                default: ;
            endcase
        end
    end

    bcm_front #(
        .BRISTLE_COUNT(BRISTLE_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_req_type       (s_axis_tuser[0]),
        .i_bristle_index  (s_axis_tdata[7:0]),
        .i_step_index     (s_axis_tdata[23:8]),
        .i_step_alpha     (s_axis_tdata[31:24]),
        .i_sample_alpha   (s_axis_tdata[39:32]),
        .i_sample_red     (s_axis_tdata[47:40]),
        .i_sample_green   (s_axis_tdata[55:48]),
        .i_sample_blue    (s_axis_tdata[63:56]),
        .i_min_alpha      (r_min_alpha),
        .i_mix_start_step (r_mix_start_step),
        .i_background_argb(r_background_argb),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    bcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_status(q_status)
    );

    bcm_back #(
        .BRISTLE_COUNT(BRISTLE_COUNT),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_cmd),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .i_mix_strength(r_mix_strength),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_bristle     (m_axis_tdata[7:0]),
        .o_red         (m_axis_tdata[15:8]),
        .o_green       (m_axis_tdata[23:16]),
        .o_blue        (m_axis_tdata[31:24])
    );

    // Queue never pushed when full, never popped when empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> !q_status.full)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) pop |-> !q_status.empty)
        else $error("pop from empty queue");
    // No result right after reset
    assert property (@(posedge i_clk) $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== dv/bristle_color_mixer_unit_test.sv =====
// Self-checking testbench for the bristle color mixer: directed table, then random phases.
`timescale 1ns / 1ps

module bristle_color_mixer_unit_test;

    import bcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DIR_ROW_COUNT  = 22;

    typedef struct packed {
        logic       req;
        logic [7:0] bristle;
        logic [15:0] step;
        logic [7:0] step_alpha;
        logic [7:0] paint_alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } brush_item_t;

    typedef struct packed {
        logic [7:0] bristle;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bristle_color_t;

    // Hand-typed color for a directed row, used instead of the computed one
    typedef struct packed {
        logic       pinned;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pinned_color_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        brush_item_t    item;
        pinned_color_t  pin;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Running colors and configuration as the mixer should hold them
    logic [23:0] run_red   [256];
    logic [23:0] run_green [256];
    logic [23:0] run_blue  [256];
    logic [STRENGTH_W-1:0] mix_weight     = MIX_STRENGTH_RST;
    logic [ALPHA_W-1:0]    alpha_floor    = MIN_ALPHA_RST;
    logic [STEP_W-1:0]     first_mix_step = MIX_START_STEP_RST;
    logic [ARGB_W-1:0]     bg_argb        = BACKGROUND_RST;

    bristle_color_t bristle_color_q [$];
    pinned_color_t  pinned_color_q [$];

    // Stimulus bookkeeping: only loaded bristles get sampled
    bit          loaded [256];
    logic [7:0]  loaded_q [$];
    logic [7:0]  last_bristle;
    bit          idle_on;
    int          stall_left;
    int          quiet_cycles;
    int          mismatch_count;
    string       field_name [4] = '{"out_bristle", "out_red", "out_green", "out_blue"};
    dir_row_t    dir_rows [DIR_ROW_COUNT];

    bristle_color_mixer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // (1 - s) * old + s * painted in 8.16, weight over 65536, truncated
    function automatic logic [23:0] blend_channel(logic [23:0] old, logic [7:0] paint,
                                                  logic [15:0] weight);
        logic [47:0] acc;
        acc = (48'd65536 - weight) * old + weight * {paint, 16'h0000};
        return acc[39:16];
    endfunction

    // Apply one accepted item to the running colors; a sample reports the bristle
    task automatic advance_bristle(input brush_item_t it, output bit has_color,
                                   output bristle_color_t color);
        logic [15:0] start_eff;
        logic [31:0] argb;
        has_color = 1'b0;
        color = '0;
        if (it.req == REQ_LOAD) begin
            run_red[it.bristle]   = {it.red, 16'h0000};
            run_green[it.bristle] = {it.green, 16'h0000};
            run_blue[it.bristle]  = {it.blue, 16'h0000};
        end else begin
            start_eff = (first_mix_step == 16'd0) ? 16'd1 : first_mix_step;
            argb = {it.paint_alpha, it.red, it.green, it.blue};
            if (it.step >= start_eff && it.step_alpha >= alpha_floor &&
                it.paint_alpha != 8'd0 && argb != bg_argb) begin
                run_red[it.bristle]   = blend_channel(run_red[it.bristle], it.red, mix_weight);
                run_green[it.bristle] = blend_channel(run_green[it.bristle], it.green,
                                                      mix_weight);
                run_blue[it.bristle]  = blend_channel(run_blue[it.bristle], it.blue, mix_weight);
            end
            has_color = 1'b1;
            color = '{it.bristle, run_red[it.bristle][23:16], run_green[it.bristle][23:16],
                      run_blue[it.bristle][23:16]};
        end
    endtask

    // Check results, track configuration writes, predict from accepted items
    always @(posedge i_clk) begin : stream_monitor
        brush_item_t    it;
        pinned_color_t  pin;
        bristle_color_t color;
        bristle_color_t want;
        bit             has_color;
        logic [31:0]    want_word;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (bristle_color_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result 0x%08h arrived with none expected", $time,
                             m_axis_tdata);
                end else begin
                    want = bristle_color_q.pop_front();
                    want_word = {want.blue, want.green, want.red, want.bristle};
                    for (int f = 0; f < 4; f++) begin
                        if (m_axis_tdata[f*8 +: 8] !== want_word[f*8 +: 8]) begin
                            mismatch_count++;
                            $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                                     field_name[f], want_word[f*8 +: 8],
                                     m_axis_tdata[f*8 +: 8]);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIX_STRENGTH:    mix_weight     = i_cfg_data[STRENGTH_W-1:0];
                    CFG_MIN_ALPHA:       alpha_floor    = i_cfg_data[ALPHA_W-1:0];
                    CFG_MIX_START_STEP:  first_mix_step = i_cfg_data[STEP_W-1:0];
                    CFG_BACKGROUND_ARGB: bg_argb        = i_cfg_data[ARGB_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it = {s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[23:8],
                      s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40],
                      s_axis_tdata[55:48], s_axis_tdata[63:56]};
                pin = pinned_color_q.pop_front();
                advance_bristle(it, has_color, color);
                if (has_color) begin
                    if (pin.pinned)
                        color = '{it.bristle, pin.red, pin.green, pin.blue};
                    bristle_color_q = {bristle_color_q, color};
                end
            end
        end
    end

    // Output back-pressure: random stall bursts that hold tready low
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // End the run when no handshake of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive one item, at times with a random gap ahead of it, and hold until accepted
    task automatic push_item(input brush_item_t it, input pinned_color_t pin);
        i_cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.blue, it.green, it.red, it.paint_alpha, it.step_alpha, it.step,
                          it.bristle};
        s_axis_tuser  <= it.req;
        pinned_color_q = {pinned_color_q, pin};
        if (it.req == REQ_LOAD && !loaded[it.bristle]) begin
            loaded[it.bristle] = 1'b1;
            loaded_q = {loaded_q, it.bristle};
        end
        last_bristle = it.bristle;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drop both valids and let every outstanding result come out
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        i_cfg_valid   <= 1'b0;
        @(posedge i_clk);
        while (bristle_color_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Valid stays high so that back-to-back writes need no lowering in between
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    function automatic dir_row_t item_row(logic req, logic [7:0] bri, logic [15:0] step,
                                          logic [7:0] sa, logic [7:0] pa, logic [7:0] r,
                                          logic [7:0] g, logic [7:0] b);
        dir_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item = '{req, bri, step, sa, pa, r, g, b};
        return row;
    endfunction

    function automatic dir_row_t pin_row(dir_row_t row, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
        row.pin = '{1'b1, r, g, b};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    // Random item: mostly samples of loaded bristles, aimed at the mixing thresholds
    task automatic send_random_item(input logic [7:0] floor_a, input logic [15:0] start,
                                    input logic [31:0] bg);
        brush_item_t it;
        logic [15:0] start_eff;
        start_eff = (start == 16'd0) ? 16'd1 : start;
        it.bristle     = 8'($urandom_range(0, 255));
        it.step        = 16'($urandom_range(0, 65535));
        it.step_alpha  = 8'($urandom_range(0, 255));
        it.paint_alpha = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        it.red         = 8'($urandom_range(0, 255));
        it.green       = 8'($urandom_range(0, 255));
        it.blue        = 8'($urandom_range(0, 255));
        if (loaded_q.size() == 0 || $urandom_range(0, 19) < 3) begin
            it.req = REQ_LOAD;
        end else begin
            it.req = REQ_SAMPLE;
            if (loaded[last_bristle] && $urandom_range(0, 2) == 0)
                it.bristle = last_bristle;
            else
                it.bristle = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
            case ($urandom_range(0, 3))
                0: ;
                1: it.step = start_eff - 16'd1 + 16'($urandom_range(0, 2));
                default: it.step = 16'($urandom_range(start_eff, 65535));
            endcase
            case ($urandom_range(0, 3))
                0: ;
                1: it.step_alpha = floor_a - 8'd1 + 8'($urandom_range(0, 2));
                default: it.step_alpha = 8'($urandom_range(floor_a, 255));
            endcase
            if ($urandom_range(0, 9) == 0)
                {it.paint_alpha, it.red, it.green, it.blue} = bg;
        end
        push_item(it, '0);
    endtask

    task automatic run_phase(input logic [15:0] weight, input logic [7:0] floor_a,
                             input logic [15:0] start, input logic [31:0] bg, input int count);
        drain_pipeline();
        write_reg(CFG_MIX_STRENGTH, {16'h0000, weight});
        write_reg(CFG_MIN_ALPHA, {24'h000000, floor_a});
        write_reg(CFG_MIX_START_STEP, {16'h0000, start});
        write_reg(CFG_BACKGROUND_ARGB, bg);
        repeat (count) send_random_item(floor_a, start, bg);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = REQ_LOAD;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_MIX_STRENGTH;
        i_cfg_data     = '0;
        idle_on        = 1'b1;
        stall_left     = 0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        last_bristle   = '0;

        // Directed rows start from the reset configuration
        dir_rows = '{
            item_row(REQ_LOAD,   8'd0,   16'd0,     8'd0,   8'd0,   8'd255, 8'd255, 8'd255),
            pin_row(item_row(REQ_SAMPLE, 8'd0, 16'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0),
                    8'd255, 8'd255, 8'd255),
            item_row(REQ_LOAD,   8'd255, 16'd65535, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0),
            pin_row(item_row(REQ_SAMPLE, 8'd255, 16'd4, 8'd255, 8'd255, 8'd255, 8'd255,
                             8'd255), 8'd0, 8'd0, 8'd0),
            pin_row(item_row(REQ_SAMPLE, 8'd255, 16'd5, 8'd19, 8'd255, 8'd255, 8'd255,
                             8'd255), 8'd0, 8'd0, 8'd0),
            pin_row(item_row(REQ_SAMPLE, 8'd255, 16'd65535, 8'd255, 8'd0, 8'd255, 8'd255,
                             8'd255), 8'd0, 8'd0, 8'd0),
            item_row(REQ_SAMPLE, 8'd255, 16'd5,     8'd20,  8'd255, 8'd255, 8'd255, 8'd255),
            item_row(REQ_SAMPLE, 8'd0,   16'd65535, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0),
            item_row(REQ_LOAD,   8'd128, 16'd0,     8'd0,   8'd0,   8'd170, 8'd85,  8'd15),
            item_row(REQ_SAMPLE, 8'd128, 16'd100,   8'd200, 8'd1,   8'd85,  8'd170, 8'd240),
            cfg_row(CFG_MIX_STRENGTH, 32'd0),
            item_row(REQ_SAMPLE, 8'd0,   16'd10,    8'd255, 8'd255, 8'd255, 8'd255, 8'd255),
            cfg_row(CFG_MIX_START_STEP, 32'd0),
            item_row(REQ_SAMPLE, 8'd255, 16'd0,     8'd255, 8'd255, 8'd0,   8'd0,   8'd0),
            item_row(REQ_SAMPLE, 8'd255, 16'd1,     8'd255, 8'd255, 8'd0,   8'd0,   8'd0),
            cfg_row(CFG_MIX_STRENGTH, 32'd65535),
            cfg_row(CFG_BACKGROUND_ARGB, 32'hFF10_2030),
            item_row(REQ_SAMPLE, 8'd128, 16'd1,     8'd255, 8'd255, 8'd16,  8'd32,  8'd48),
            item_row(REQ_SAMPLE, 8'd128, 16'd1,     8'd255, 8'd254, 8'd16,  8'd32,  8'd48),
            cfg_row(CFG_MIN_ALPHA, 32'd255),
            item_row(REQ_SAMPLE, 8'd128, 16'd65535, 8'd254, 8'd255, 8'd0,   8'd255, 8'd0),
            item_row(REQ_SAMPLE, 8'd128, 16'd65535, 8'd255, 8'd255, 8'd0,   8'd255, 8'd0)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; registers change only with the pipeline empty
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_pipeline();
                write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
            end else begin
                push_item(dir_rows[r].item, dir_rows[r].pin);
            end
        end

        // Random phases: both extremes, the reset settings, then random settings
        run_phase(16'd0, 8'd0, 16'd0, 32'd0, 200);
        run_phase(16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 150);
        run_phase(MIX_STRENGTH_RST, MIN_ALPHA_RST, MIX_START_STEP_RST, BACKGROUND_RST, 250);
        for (int p = 0; p < 5; p++) begin
            idle_on = (p == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
            run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 64)),
                      16'($urandom_range(1, 300)), $urandom, 200);
        end

        drain_pipeline();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
